// ----- src/hcbd_pkg.sv -----
// Package for the chunked HTTP body decoder: item types, result codes,
// parser phases and the hex digit decoder. No dependencies.
package hcbd_pkg;

    // One raw body byte with its stream controls.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       begin_body;
        logic       stream_closed;
    } in_item_t;

    // One decoded result.
    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] payload_byte;
    } out_item_t;

    // Result of one parser step, handed from the core to the output register.
    typedef struct packed {
        logic      valid;
        out_item_t item;
    } step_res_t;

    typedef enum logic [2:0] {
        PH_SIZE,
        PH_DATA,
        PH_TRAILER,
        PH_DONE,
        PH_ERROR
    } phase_t;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    // Line length counter saturates here; two is enough to tell empty lines.
    localparam logic [1:0] LINE_SAT = 2'd2;

    // Bit 4 is set when the character is a hex digit; bits 3:0 hold its value.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        begin
            r = 5'd0;
            if (c >= 8'h30 && c <= 8'h39) begin
                r = {1'b1, 4'(c - 8'h30)};
            end else if (c >= 8'h61 && c <= 8'h66) begin
                r = {1'b1, 4'(c - 8'h57)};
            end else if (c >= 8'h41 && c <= 8'h46) begin
                r = {1'b1, 4'(c - 8'h37)};
            end
            return r;
        end
    endfunction

endpackage

// ----- src/hcbd_core.sv -----
// Parser state and next-state logic of the chunked body decoder.
// Depends on hcbd_pkg. Advances by one item whenever step is high.
module hcbd_core #(
    parameter int MAX_HEX_DIGITS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  hcbd_pkg::in_item_t  item,
    output hcbd_pkg::step_res_t res
);

    localparam int CW  = 4 * MAX_HEX_DIGITS;
    localparam int DCW = $clog2(MAX_HEX_DIGITS + 1);

    hcbd_pkg::phase_t phase_reg, phase_next, eff_phase;
    logic [CW-1:0]    rem_reg, rem_next, eff_rem, rem_dec, rem_shift;
    logic [DCW-1:0]   dc_reg, dc_next, eff_dc;
    logic             stop_reg, stop_next, eff_stop;
    logic [1:0]       lc_reg, lc_next, eff_lc;
    logic             cr_reg, cr_next, eff_cr;
    logic             first_reg, first_next, eff_first;
    logic             tm_reg, tm_next, eff_tm;
    logic [4:0]       hexv;
    logic             line_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= hcbd_pkg::PH_SIZE;
            rem_reg   <= '0;
            dc_reg    <= '0;
            stop_reg  <= 1'b0;
            lc_reg    <= 2'd0;
            cr_reg    <= 1'b0;
            first_reg <= 1'b1;
            tm_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
            dc_reg    <= dc_next;
            stop_reg  <= stop_next;
            lc_reg    <= lc_next;
            cr_reg    <= cr_next;
            first_reg <= first_next;
            tm_reg    <= tm_next;
        end
    end

    always_comb
    begin
        // begin_body clears the decoder before the byte is looked at.
        eff_phase = item.begin_body ? hcbd_pkg::PH_SIZE : phase_reg;
        eff_rem   = item.begin_body ? '0 : rem_reg;
        eff_dc    = item.begin_body ? '0 : dc_reg;
        eff_stop  = item.begin_body ? 1'b0 : stop_reg;
        eff_lc    = item.begin_body ? 2'd0 : lc_reg;
        eff_cr    = item.begin_body ? 1'b0 : cr_reg;
        eff_first = item.begin_body ? 1'b1 : first_reg;
        eff_tm    = item.begin_body ? 1'b0 : tm_reg;

        phase_next = eff_phase;
        rem_next   = eff_rem;
        dc_next    = eff_dc;
        stop_next  = eff_stop;
        lc_next    = eff_lc;
        cr_next    = eff_cr;
        first_next = eff_first;
        tm_next    = eff_tm;

        res                   = '0;
        res.item.result_kind  = hcbd_pkg::KIND_DATA;

        hexv       = hcbd_pkg::hex_decode(item.in_byte);
        rem_dec    = eff_rem - CW'(1);
        rem_shift  = (eff_rem << 4) | CW'(hexv[3:0]);
        line_empty = (eff_lc == 2'd0) || (eff_lc == 2'd1 && eff_cr);

        if (item.stream_closed)
        begin
            if (eff_phase != hcbd_pkg::PH_DONE && eff_phase != hcbd_pkg::PH_ERROR)
            begin
                phase_next           = hcbd_pkg::PH_ERROR;
                res.valid            = 1'b1;
                res.item.result_kind = hcbd_pkg::KIND_ERR;
            end
        end
        else
        begin
            case (eff_phase)
                hcbd_pkg::PH_DATA:
                begin
                    rem_next              = rem_dec;
                    res.valid             = 1'b1;
                    res.item.payload_byte = item.in_byte;
                    if (rem_dec == '0)
                    begin
                        phase_next = hcbd_pkg::PH_SIZE;
                        first_next = 1'b0;
                        dc_next    = '0;
                        stop_next  = 1'b0;
                        lc_next    = 2'd0;
                        cr_next    = 1'b0;
                        tm_next    = 1'b0;
                    end
                end
                hcbd_pkg::PH_SIZE, hcbd_pkg::PH_TRAILER:
                begin
                    if (item.in_byte != hcbd_pkg::CHAR_LF)
                    begin
                        // Only the leading hex digits of a size line count.
                        if (eff_phase == hcbd_pkg::PH_SIZE && eff_first && !eff_stop)
                        begin
                            if (!hexv[4])
                            begin
                                stop_next = 1'b1;
                            end
                            else if (eff_dc >= DCW'(MAX_HEX_DIGITS))
                            begin
                                tm_next = 1'b1;
                            end
                            else
                            begin
                                rem_next = rem_shift;
                                dc_next  = eff_dc + DCW'(1);
                            end
                        end
                        if (eff_lc < hcbd_pkg::LINE_SAT)
                        begin
                            lc_next = eff_lc + 2'd1;
                        end
                        cr_next = (item.in_byte == hcbd_pkg::CHAR_CR);
                    end
                    else
                    begin
                        dc_next   = '0;
                        stop_next = 1'b0;
                        lc_next   = 2'd0;
                        cr_next   = 1'b0;
                        tm_next   = 1'b0;
                        if (eff_phase == hcbd_pkg::PH_TRAILER)
                        begin
                            if (line_empty)
                            begin
                                phase_next           = hcbd_pkg::PH_DONE;
                                res.valid            = 1'b1;
                                res.item.result_kind = hcbd_pkg::KIND_DONE;
                            end
                        end
                        else if (!eff_first)
                        begin
                            // The line that closes chunk data must be empty.
                            if (!line_empty)
                            begin
                                phase_next           = hcbd_pkg::PH_ERROR;
                                res.valid            = 1'b1;
                                res.item.result_kind = hcbd_pkg::KIND_ERR;
                            end
                            else
                            begin
                                first_next = 1'b1;
                            end
                        end
                        else if (line_empty || eff_tm)
                        begin
                            phase_next           = hcbd_pkg::PH_ERROR;
                            res.valid            = 1'b1;
                            res.item.result_kind = hcbd_pkg::KIND_ERR;
                        end
                        else
                        begin
                            phase_next = (eff_rem == '0) ? hcbd_pkg::PH_TRAILER
                                                         : hcbd_pkg::PH_DATA;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    a_done_from_trailer: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.valid && res.item.result_kind == hcbd_pkg::KIND_DONE
        |-> phase_reg == hcbd_pkg::PH_TRAILER && !item.begin_body)
        else $error("completion reported outside trailer phase");

    a_digit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dc_reg <= DCW'(MAX_HEX_DIGITS))
        else $error("hex digit count beyond limit");

    a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == hcbd_pkg::PH_DATA |-> rem_reg != '0)
        else $error("data phase with nothing remaining");

    a_err_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.valid && res.item.result_kind == hcbd_pkg::KIND_ERR
        |=> phase_reg == hcbd_pkg::PH_ERROR)
        else $error("error result without error phase");

endmodule

// ----- src/hcbd_out_reg.sv -----
// Result register of the chunked body decoder: holds one result until taken.
// Depends on hcbd_pkg.
module hcbd_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  hcbd_pkg::step_res_t res,
    input  logic                result_stall,
    output logic                result_valid,
    output hcbd_pkg::out_item_t result
);

    logic                valid_reg, valid_next;
    hcbd_pkg::out_item_t item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (!valid_reg || !result_stall)
        begin
            valid_next = step && res.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res.valid)
        begin
            item_reg <= res.item;
        end
    end

    assign result_valid = valid_reg;
    assign result       = item_reg;

endmodule

// ----- src/http_chunked_body_decoder_top.sv -----
// Chunked HTTP body decoder, top level: input register and handshake control.
// Depends on hcbd_pkg, hcbd_core and hcbd_out_reg.
// An accepted item is held in the input register; its result is registered in
// the result register. Throughput: one item per cycle while results are not
// stalled, set by the combinational parser step between the two registers.
// Reset (rst_n low, asynchronous) empties both registers and clears the parser.
module http_chunked_body_decoder_top #(
    parameter int MAX_HEX_DIGITS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                body_valid,
    output logic                body_stall,
    input  hcbd_pkg::in_item_t  body,
    output logic                result_valid,
    input  logic                result_stall,
    output hcbd_pkg::out_item_t result
);

    logic                in_valid_reg, in_valid_next;
    hcbd_pkg::in_item_t  in_item_reg;
    logic                step;
    hcbd_pkg::step_res_t step_res;

    // The held item moves on whenever the result register can take its result.
    assign step       = in_valid_reg && (!result_valid || !result_stall);
    assign body_stall = in_valid_reg && !step;

    assign in_valid_next = (body_valid && !body_stall) || (in_valid_reg && !step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (body_valid && !body_stall)
        begin
            in_item_reg <= body;
        end
    end

    hcbd_core #(
        .MAX_HEX_DIGITS(MAX_HEX_DIGITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (in_item_reg),
        .res   (step_res)
    );

    hcbd_out_reg u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .res          (step_res),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
